### hdl/sms_pkg.sv
// sms_pkg: shared types and constants for the saber mode sequencer
// holds mode, sound and blade codes, register indexes and the state structs
// no dependencies
package sms_pkg;

   // fixed timing constants
   localparam logic [31:0] CLASH_REPEAT_MS    = 32'd200;
   localparam logic [31:0] SWING_CLASH_GAP_MS = 32'd100;

   // stream payload widths
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [3:0] {
      MODE_BOOT      = 4'd0,
      MODE_OFF       = 4'd1,
      MODE_UP        = 4'd2,
      MODE_IDLE      = 4'd3,
      MODE_SWING     = 4'd4,
      MODE_POSTSWING = 4'd5,
      MODE_CLASH     = 4'd6,
      MODE_POSTCLASH = 4'd7,
      MODE_DOWN      = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      SND_NONE     = 3'd0,
      SND_BOOT     = 3'd1,
      SND_POWER_UP = 3'd2,
      SND_HUM      = 3'd3,
      SND_SWING    = 3'd4,
      SND_CLASH    = 3'd5,
      SND_POWER_DN = 3'd6
   } sound_type;

   typedef enum logic [2:0] {
      BLD_NONE    = 3'd0,
      BLD_NORMAL  = 3'd1,
      BLD_FLASH   = 3'd2,
      BLD_RAMP_UP = 3'd3,
      BLD_RAMP_DN = 3'd4,
      BLD_FLICKER = 3'd5
   } blade_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEBOUNCE   = 3'd0,
      REG_PD_HOLD    = 3'd1,
      REG_MIN_SWING  = 3'd2,
      REG_MAX_SWING  = 3'd3,
      REG_CLASH_PULS = 3'd4,
      REG_POST_CLASH = 3'd5,
      REG_HUM        = 3'd6,
      REG_SWING_THR  = 3'd7
   } reg_idx_type;

   // configuration register file contents
   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] power_down_hold_ms;
      logic [15:0] min_swing_ms;
      logic [15:0] max_swing_ms;
      logic [15:0] clash_pulse_ms;
      logic [15:0] post_clash_ms;
      logic [19:0] hum_relaunch_ms;
      logic [2:0]  swing_threshold;
   } cfg_type;

   // one input item
   typedef struct packed {
      logic        blade_done;
      logic [2:0]  swing_magnitude;
      logic        swing_seen;
      logic        clash_seen;
      logic [15:0] act_held_ms;
      logic        act_held;
      logic [15:0] act_pulse_width_ms;
      logic        act_pulse_edge;
      logic [31:0] now_ms;
   } req_type;

   // one result item
   typedef struct packed {
      blade_type blade_cmd;
      sound_type sound_cmd;
      mode_type  mode;
   } rsp_type;

   // sequencer state
   typedef struct packed {
      mode_type    mode;
      logic [31:0] entry_time;
      logic        fresh;
      logic [31:0] last_clash_time;
      logic        await_release;
   } state_type;

endpackage

### hdl/saber_mode_sequencer.sv
// saber_mode_sequencer: top level of the saber mode sequencer
// depends on sms_pkg, sms_csr and sms_step
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  req_tdata  72 bits, one loop pass
//   rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata  16 bits, mode and commands
//   csr_     in   csr_valid/csr_ready    csr_index 3 bits, csr_data 20 bits
//
// one item per cycle unless the result side stalls; each item is held in
// the input register, then evaluated against the state and written to the
// result register.
// reset is synchronous: state goes to boot with a fresh pass, registers to
// their defaults. a stalled result holds while one more item is taken into
// the input register; csr writes are always taken.
module saber_mode_sequencer
   import sms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // now_ms[31:0], act_pulse_edge[32], act_pulse_width_ms[48:33],
   // act_held[49], act_held_ms[65:50], clash_seen[66], swing_seen[67],
   // swing_magnitude[70:68], blade_done[71]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mode[3:0], sound_cmd[6:4], blade_cmd[9:7], zeros[15:10]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type   cfg;
   req_type   req_ff;
   logic      in_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      out_valid_ff;
   state_type state_ff;
   state_type state_in;
   logic      fire;

   sms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sms_step u_step (
      .st    (state_ff),
      .cfg   (cfg),
      .req   (req_ff),
      .st_in (state_in),
      .rsp   (rsp_in)
   );

   // evaluate when an item waits and the result register can take it
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_ff};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff <= req_type'(req_tdata);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode            <= MODE_BOOT;
         state_ff.entry_time      <= 32'd0;
         state_ff.fresh           <= 1'b1;
         state_ff.last_clash_time <= 32'd0;
         state_ff.await_release   <= 1'b0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // boot lasts exactly one pass
   a_boot_to_off: assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff.mode == MODE_BOOT) |=> (state_ff.mode == MODE_OFF))
      else $error("boot pass did not move to off");

   // every mode change starts a fresh pass with no pending release
   a_change_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode != $past(state_ff.mode)) |-> (state_ff.fresh && !state_ff.await_release))
      else $error("mode change without fresh flag");

   // an evaluated item always lands in the result register
   a_fire_out: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("evaluated item lost");
`endif

endmodule

### hdl/sms_csr.sv
// sms_csr: configuration register file for the saber mode sequencer
// depends on sms_pkg for register indexes and the cfg_type struct
module sms_csr
   import sms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register writes, one per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= 16'd50;
         cfg_ff.power_down_hold_ms <= 16'd1500;
         cfg_ff.min_swing_ms       <= 16'd200;
         cfg_ff.max_swing_ms       <= 16'd1000;
         cfg_ff.clash_pulse_ms     <= 16'd100;
         cfg_ff.post_clash_ms      <= 16'd1000;
         cfg_ff.hum_relaunch_ms    <= 20'd30000;
         cfg_ff.swing_threshold    <= 3'd1;
      end else if (csr_valid) begin
         unique case (reg_idx_type'(csr_index))
            REG_DEBOUNCE:   cfg_ff.debounce_ms        <= csr_data[15:0];
            REG_PD_HOLD:    cfg_ff.power_down_hold_ms <= csr_data[15:0];
            REG_MIN_SWING:  cfg_ff.min_swing_ms       <= csr_data[15:0];
            REG_MAX_SWING:  cfg_ff.max_swing_ms       <= csr_data[15:0];
            REG_CLASH_PULS: cfg_ff.clash_pulse_ms     <= csr_data[15:0];
            REG_POST_CLASH: cfg_ff.post_clash_ms      <= csr_data[15:0];
            REG_HUM:        cfg_ff.hum_relaunch_ms    <= csr_data[19:0];
            REG_SWING_THR:  cfg_ff.swing_threshold    <= csr_data[2:0];
            default: ;
         endcase
      end
   end

endmodule

### hdl/sms_step.sv
// sms_step: combinational next-state and command logic for one loop pass
// depends on sms_pkg for mode, sound and blade codes and the state structs
module sms_step
   import sms_pkg::*;
(
   input  state_type st,
   input  cfg_type   cfg,
   input  req_type   req,
   output state_type st_in,
   output rsp_type   rsp
);

   logic [31:0] elapsed;
   logic [31:0] since_clash;
   logic        hold_off;
   logic        go;
   mode_type    target;
   logic        await_now;

   assign elapsed     = req.now_ms - st.entry_time;
   assign since_clash = req.now_ms - st.last_clash_time;
   assign hold_off    = req.act_held && (req.act_held_ms >= cfg.power_down_hold_ms);

   // per-mode decisions
   always_comb begin
      st_in         = st;
      st_in.fresh   = 1'b0;
      rsp.mode      = st.mode;
      rsp.sound_cmd = SND_NONE;
      rsp.blade_cmd = BLD_NONE;
      go            = 1'b0;
      target        = st.mode;
      await_now     = st.await_release;
      unique case (st.mode)
         MODE_BOOT: begin
            rsp.sound_cmd = SND_BOOT;
            go            = 1'b1;
            target        = MODE_OFF;
         end
         MODE_OFF: begin
            if (req.act_pulse_edge && (req.act_pulse_width_ms > cfg.debounce_ms)) begin
               go     = 1'b1;
               target = MODE_UP;
            end
         end
         MODE_UP: begin
            rsp.blade_cmd = BLD_RAMP_UP;
            if (st.fresh) begin
               rsp.sound_cmd = SND_POWER_UP;
            end else if (req.blade_done) begin
               go     = 1'b1;
               target = MODE_IDLE;
            end
         end
         MODE_IDLE: begin
            priority if (hold_off) begin
               go     = 1'b1;
               target = MODE_DOWN;
            end else if (req.clash_seen) begin
               go     = 1'b1;
               target = MODE_CLASH;
            end else if (req.swing_seen && (req.swing_magnitude > cfg.swing_threshold)) begin
               go     = 1'b1;
               target = MODE_SWING;
            end else if (elapsed >= {12'd0, cfg.hum_relaunch_ms}) begin
               rsp.sound_cmd    = SND_HUM;
               st_in.entry_time = req.now_ms;
            end else begin
               rsp.blade_cmd = BLD_FLICKER;
            end
            // first pass in idle shows the normal color instead
            if (st.fresh) begin
               rsp.blade_cmd = BLD_NORMAL;
            end
         end
         MODE_SWING: begin
            rsp.sound_cmd = SND_SWING;
            go            = 1'b1;
            target        = MODE_POSTSWING;
         end
         MODE_POSTSWING: begin
            // await_release marks a pending clash here
            priority if (st.await_release) begin
               if (elapsed > SWING_CLASH_GAP_MS) begin
                  go     = 1'b1;
                  target = MODE_CLASH;
               end
            end else if (hold_off) begin
               go     = 1'b1;
               target = MODE_DOWN;
            end else if (req.clash_seen) begin
               if (elapsed > SWING_CLASH_GAP_MS) begin
                  go     = 1'b1;
                  target = MODE_CLASH;
               end else begin
                  st_in.await_release = 1'b1;
               end
            end else if (!req.swing_seen && (elapsed >= {16'd0, cfg.min_swing_ms})) begin
               go     = 1'b1;
               target = MODE_IDLE;
            end else if (elapsed > {16'd0, cfg.max_swing_ms}) begin
               go     = 1'b1;
               target = MODE_IDLE;
            end else begin
               // stay in post swing
            end
         end
         MODE_CLASH: begin
            if (st.fresh) begin
               st_in.last_clash_time = req.now_ms;
               rsp.sound_cmd         = SND_CLASH;
               rsp.blade_cmd         = BLD_FLASH;
            end
            // end of the flash pulse
            if (elapsed > {16'd0, cfg.clash_pulse_ms}) begin
               rsp.blade_cmd = BLD_NORMAL;
               go            = 1'b1;
               target        = MODE_POSTCLASH;
            end
         end
         MODE_POSTCLASH: begin
            priority if (req.clash_seen && (since_clash > CLASH_REPEAT_MS)) begin
               go     = 1'b1;
               target = MODE_CLASH;
            end else if (elapsed >= {16'd0, cfg.post_clash_ms}) begin
               go     = 1'b1;
               target = MODE_IDLE;
            end else begin
               // stay in post clash
            end
         end
         MODE_DOWN: begin
            if (st.fresh) begin
               rsp.sound_cmd = SND_POWER_DN;
            end
            // ramp down until done, then wait for button release
            if (!st.await_release) begin
               rsp.blade_cmd = BLD_RAMP_DN;
               if (!st.fresh && req.blade_done) begin
                  await_now = 1'b1;
               end
            end
            st_in.await_release = await_now;
            if (await_now && !req.act_held && !req.act_pulse_edge) begin
               go     = 1'b1;
               target = MODE_OFF;
            end
         end
         default: ;
      endcase
      // mode change
      if (go) begin
         st_in.mode          = target;
         st_in.entry_time    = req.now_ms;
         st_in.fresh         = 1'b1;
         st_in.await_release = 1'b0;
      end
   end

endmodule

### verif/saber_mode_sequencer_test.sv
// saber_mode_sequencer_test: self-checking bench for the saber mode sequencer
// runs a directed pass table, then random loop passes under several register settings,
// and checks each result against its typed table row or its own mode predictor; depends on sms_pkg
module saber_mode_sequencer_test;
   import sms_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int DRILL_ROWS   = 25;
   localparam int CMD_W        = $bits(rsp_type);

   // dut ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state and register copy
   state_type   sab;
   cfg_type     regs;
   logic [31:0] wall_ms;
   logic [8:0]  modes_seen;

   // commands still owed by the block, oldest first
   rsp_type     due_cmds[$];

   int unsigned send_max;
   int unsigned recv_max;
   int          failures;
   int          rsp_seen;
   int          passes_sent;
   int          cycles;

   typedef struct {
      logic [31:0] now;
      logic        pedge;
      logic [15:0] pwidth;
      logic        held;
      logic [15:0] held_ms;
      logic        clash;
      logic        swing;
      logic [2:0]  mag;
      logic        done;
      logic        typed;
      mode_type    mode;
      sound_type   snd;
      blade_type   blade;
   } drill_row_type;

   drill_row_type drill [DRILL_ROWS];

   saber_mode_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // one loop pass of the sequencer: returns the commands, advances sab
   function automatic rsp_type saber_pass(input req_type r);
      rsp_type     o;
      logic [31:0] elapsed;
      logic        hold_off;
      logic        fresh;
      logic        moved;
      mode_type    nxt;
      o.mode      = sab.mode;
      o.sound_cmd = SND_NONE;
      o.blade_cmd = BLD_NONE;
      elapsed  = r.now_ms - sab.entry_time;
      hold_off = r.act_held && (r.act_held_ms >= regs.power_down_hold_ms);
      fresh    = sab.fresh;
      moved    = 1'b0;
      nxt      = sab.mode;
      case (sab.mode)
         MODE_BOOT: begin
            o.sound_cmd = SND_BOOT;
            nxt = MODE_OFF; moved = 1'b1;
         end
         MODE_OFF: begin
            if (r.act_pulse_edge && r.act_pulse_width_ms > regs.debounce_ms) begin
               nxt = MODE_UP; moved = 1'b1;
            end
         end
         MODE_UP: begin
            o.blade_cmd = BLD_RAMP_UP;
            // a done flag on the first pass may be left over from before
            if (fresh) o.sound_cmd = SND_POWER_UP;
            else if (r.blade_done) begin
               nxt = MODE_IDLE; moved = 1'b1;
            end
         end
         MODE_IDLE: begin
            if (hold_off) begin
               nxt = MODE_DOWN; moved = 1'b1;
            end else if (r.clash_seen) begin
               nxt = MODE_CLASH; moved = 1'b1;
            end else if (r.swing_seen && r.swing_magnitude > regs.swing_threshold) begin
               nxt = MODE_SWING; moved = 1'b1;
            end else if (elapsed >= {12'd0, regs.hum_relaunch_ms}) begin
               o.sound_cmd = SND_HUM;
               sab.entry_time = r.now_ms;
            end else begin
               o.blade_cmd = BLD_FLICKER;
            end
            if (fresh) o.blade_cmd = BLD_NORMAL;
         end
         MODE_SWING: begin
            o.sound_cmd = SND_SWING;
            nxt = MODE_POSTSWING; moved = 1'b1;
         end
         MODE_POSTSWING: begin
            // await_release doubles as a pending clash here
            if (sab.await_release) begin
               if (elapsed > SWING_CLASH_GAP_MS) begin
                  nxt = MODE_CLASH; moved = 1'b1;
               end
            end else if (hold_off) begin
               nxt = MODE_DOWN; moved = 1'b1;
            end else if (r.clash_seen) begin
               if (elapsed > SWING_CLASH_GAP_MS) begin
                  nxt = MODE_CLASH; moved = 1'b1;
               end else begin
                  sab.await_release = 1'b1;
               end
            end else if (!r.swing_seen && elapsed >= {16'd0, regs.min_swing_ms}) begin
               nxt = MODE_IDLE; moved = 1'b1;
            end else if (elapsed > {16'd0, regs.max_swing_ms}) begin
               nxt = MODE_IDLE; moved = 1'b1;
            end
         end
         MODE_CLASH: begin
            if (fresh) begin
               sab.last_clash_time = r.now_ms;
               o.sound_cmd = SND_CLASH;
               o.blade_cmd = BLD_FLASH;
            end
            if (elapsed > {16'd0, regs.clash_pulse_ms}) begin
               o.blade_cmd = BLD_NORMAL;
               nxt = MODE_POSTCLASH; moved = 1'b1;
            end
         end
         MODE_POSTCLASH: begin
            if (r.clash_seen && (r.now_ms - sab.last_clash_time) > CLASH_REPEAT_MS) begin
               nxt = MODE_CLASH; moved = 1'b1;
            end else if (elapsed >= {16'd0, regs.post_clash_ms}) begin
               nxt = MODE_IDLE; moved = 1'b1;
            end
         end
         MODE_DOWN: begin
            if (fresh) o.sound_cmd = SND_POWER_DN;
            if (!sab.await_release) begin
               o.blade_cmd = BLD_RAMP_DN;
               if (!fresh && r.blade_done) sab.await_release = 1'b1;
            end
            if (sab.await_release && !r.act_held && !r.act_pulse_edge) begin
               nxt = MODE_OFF; moved = 1'b1;
            end
         end
         default: ;
      endcase
      if (moved) begin
         sab.mode          = nxt;
         sab.entry_time    = r.now_ms;
         sab.fresh         = 1'b1;
         sab.await_release = 1'b0;
      end else begin
         sab.fresh = 1'b0;
      end
      modes_seen[int'(o.mode)] = 1'b1;
      return o;
   endfunction

   function automatic logic coin(input int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // a value one below, at or one above a register threshold
   function automatic logic [15:0] near16(input logic [15:0] v);
      int w;
      w = int'(v) + int'($urandom_range(0, 2)) - 1;
      if (w < 0) w = 0;
      if (w > 65535) w = 65535;
      return 16'(w);
   endfunction

   // next random pass, shaped by the mode the predictor is in
   function automatic req_type make_pass();
      req_type     p;
      int unsigned pick;
      logic [31:0] rnd;
      logic [31:0] rnd2;
      pick = $urandom_range(0, 99);
      if (pick < 60) wall_ms += $urandom_range(0, 40);
      else if (pick < 85) wall_ms += $urandom_range(0, 300);
      else if (pick < 95) wall_ms += $urandom_range(0, 3000);
      else if (pick < 99) wall_ms += $urandom_range(0, 70000);
      else wall_ms += $urandom;
      p = '0;
      p.now_ms = wall_ms;
      rnd  = $urandom;
      rnd2 = $urandom;
      // noise: every field but the time is random
      if (coin(10)) begin
         p[REQ_DATA_W-1:32] = {rnd2[7:0], rnd};
         return p;
      end
      case (sab.mode)
         MODE_OFF: begin
            p.act_pulse_edge = coin(50);
            p.act_pulse_width_ms = coin(60) ? near16(regs.debounce_ms) : rnd[15:0];
            p.act_held = coin(20);
         end
         MODE_UP: p.blade_done = coin(40);
         MODE_IDLE: begin
            if (coin(6)) begin
               p.act_held = 1'b1;
               p.act_held_ms = near16(regs.power_down_hold_ms);
            end else if (coin(15)) begin
               p.act_held = 1'b1;
               p.act_held_ms = rnd[15:0];
            end
            p.clash_seen = coin(8);
            p.swing_seen = coin(25);
            p.swing_magnitude = rnd2[2:0];
         end
         MODE_POSTSWING: begin
            p.clash_seen = coin(20);
            p.swing_seen = coin(50);
            p.swing_magnitude = rnd2[2:0];
            p.act_held = coin(5);
            p.act_held_ms = rnd[15:0];
         end
         MODE_POSTCLASH: p.clash_seen = coin(30);
         MODE_DOWN: begin
            p.blade_done = coin(40);
            p.act_held = coin(50);
            p.act_pulse_edge = coin(15);
            p.act_held_ms = rnd[15:0];
         end
         default: ;
      endcase
      return p;
   endfunction

   // offer one pass, predict it once the transfer happens
   task automatic send_pass(input req_type r, input int unsigned gap,
                            input logic typed, input rsp_type typed_cmd);
      rsp_type got;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      got = saber_pass(r);
      due_cmds.push_back(typed ? typed_cmd : got);
      passes_sent++;
      @(negedge clock);
   endtask

   // write all eight registers back to back
   task automatic write_settings(input cfg_type c);
      reg_idx_type           order [8];
      reg_idx_type           idx;
      logic [CSR_DATA_W-1:0] val;
      int                    k;
      order = '{REG_DEBOUNCE, REG_PD_HOLD, REG_MIN_SWING, REG_MAX_SWING,
                REG_CLASH_PULS, REG_POST_CLASH, REG_HUM, REG_SWING_THR};
      for (k = 0; k < 8; k++) begin
         idx = order[k];
         case (idx)
            REG_DEBOUNCE:   val = {4'd0, c.debounce_ms};
            REG_PD_HOLD:    val = {4'd0, c.power_down_hold_ms};
            REG_MIN_SWING:  val = {4'd0, c.min_swing_ms};
            REG_MAX_SWING:  val = {4'd0, c.max_swing_ms};
            REG_CLASH_PULS: val = {4'd0, c.clash_pulse_ms};
            REG_POST_CLASH: val = {4'd0, c.post_clash_ms};
            REG_HUM:        val = c.hum_relaunch_ms;
            default:        val = {17'd0, c.swing_threshold};
         endcase
         csr_index <= idx;
         csr_data  <= val;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!(csr_valid && csr_ready));
         case (idx)
            REG_DEBOUNCE:   regs.debounce_ms        = val[15:0];
            REG_PD_HOLD:    regs.power_down_hold_ms = val[15:0];
            REG_MIN_SWING:  regs.min_swing_ms       = val[15:0];
            REG_MAX_SWING:  regs.max_swing_ms       = val[15:0];
            REG_CLASH_PULS: regs.clash_pulse_ms     = val[15:0];
            REG_POST_CLASH: regs.post_clash_ms      = val[15:0];
            REG_HUM:        regs.hum_relaunch_ms    = val;
            default:        regs.swing_threshold    = val[2:0];
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // stop offering and wait for every owed result
   task automatic drain();
      req_tvalid <= 1'b0;
      while (due_cmds.size() > 0) @(posedge clock);
      @(negedge clock);
   endtask

   // result side: random stalls plus one long hold-off to back up the block
   initial begin : rsp_side
      int unsigned stall;
      bit          long_hold_done;
      long_hold_done = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (!long_hold_done && rsp_seen >= 100) begin
            stall = 300;
            long_hold_done = 1'b1;
         end else begin
            stall = $urandom_range(0, recv_max);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // result check against the oldest owed commands
   always @(posedge clock) begin : check_rsp
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         got = rsp_tdata[CMD_W-1:0];
         if (due_cmds.size() == 0) begin
            $error("result with no pass outstanding: tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = due_cmds.pop_front();
            if (got.mode !== want.mode) begin
               $error("mode mismatch: expected %0d actual %0d", want.mode, got.mode);
               failures++;
            end
            if (got.sound_cmd !== want.sound_cmd) begin
               $error("sound_cmd mismatch: expected %0d actual %0d",
                      want.sound_cmd, got.sound_cmd);
               failures++;
            end
            if (got.blade_cmd !== want.blade_cmd) begin
               $error("blade_cmd mismatch: expected %0d actual %0d",
                      want.blade_cmd, got.blade_cmd);
               failures++;
            end
            if (rsp_tdata[RSP_DATA_W-1:CMD_W] !== '0) begin
               $error("tdata padding mismatch: expected 0 actual %h",
                      rsp_tdata[RSP_DATA_W-1:CMD_W]);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      req_type     r;
      rsp_type     t;
      cfg_type     cset;
      int          k;
      int          ph;
      int          n;
      int unsigned phase_len [6];
      int unsigned phase_send [6];
      int unsigned phase_recv [6];
      int          settings_done;

      failures = 0; rsp_seen = 0; passes_sent = 0; cycles = 0;
      settings_done = 0;
      modes_seen = '0;
      send_max = 10;
      recv_max = 10;
      phase_len  = '{300, 200, 200, 250, 250, 250};
      phase_send = '{0, 10, 10, 0, 10, 3};
      phase_recv = '{10, 10, 0, 0, 10, 10};

      // predictor starts in boot with default registers
      sab.mode = MODE_BOOT;
      sab.entry_time = '0;
      sab.fresh = 1'b1;
      sab.last_clash_time = '0;
      sab.await_release = 1'b0;
      regs.debounce_ms = 16'd50;
      regs.power_down_hold_ms = 16'd1500;
      regs.min_swing_ms = 16'd200;
      regs.max_swing_ms = 16'd1000;
      regs.clash_pulse_ms = 16'd100;
      regs.post_clash_ms = 16'd1000;
      regs.hum_relaunch_ms = 20'd30000;
      regs.swing_threshold = 3'd1;

      // now, edge, width, held, held_ms, clash, swing, mag, done, typed, mode, sound, blade
      drill = '{
         '{32'd0,     0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 1,
           MODE_BOOT, SND_BOOT, BLD_NONE},
         // pulse exactly at the debounce width is too short
         '{32'd10,    1, 16'd50,    0, 16'd0,     0, 0, 3'd0, 0, 1,
           MODE_OFF, SND_NONE, BLD_NONE},
         '{32'd20,    1, 16'd51,    0, 16'd0,     0, 0, 3'd0, 0, 1,
           MODE_OFF, SND_NONE, BLD_NONE},
         // stale done flag on the first powering up pass
         '{32'd30,    0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 1, 1,
           MODE_UP, SND_POWER_UP, BLD_RAMP_UP},
         '{32'd40,    0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 1, 1,
           MODE_UP, SND_NONE, BLD_RAMP_UP},
         // first idle pass gives normal color instead of flicker
         '{32'd50,    0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 1,
           MODE_IDLE, SND_NONE, BLD_NORMAL},
         '{32'd60,    0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 1,
           MODE_IDLE, SND_NONE, BLD_FLICKER},
         // hum relaunch right at the interval
         '{32'd30040, 0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30050, 0, 16'd0,     0, 16'd0,     0, 1, 3'd1, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30060, 0, 16'd0,     0, 16'd0,     0, 1, 3'd7, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30070, 0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 1,
           MODE_SWING, SND_SWING, BLD_NONE},
         // early clash in post swing is held pending
         '{32'd30100, 0, 16'd0,     0, 16'd0,     1, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30170, 0, 16'd0,     0, 16'd0,     0, 1, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30171, 0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30171, 0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 1,
           MODE_CLASH, SND_CLASH, BLD_FLASH},
         // clash pulse end swaps flash for normal color
         '{32'd30272, 0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30300, 0, 16'd0,     0, 16'd0,     1, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30400, 0, 16'd0,     0, 16'd0,     1, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30400, 0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd30600, 0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd31600, 0, 16'd0,     0, 16'd0,     0, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         // long hold wins over clash and swing, all fields but the time at their top
         '{32'd31601, 1, 16'hFFFF,  1, 16'hFFFF,  1, 1, 3'd7, 1, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         '{32'd31602, 0, 16'd0,     1, 16'd1500,  0, 0, 3'd0, 1, 1,
           MODE_DOWN, SND_POWER_DN, BLD_RAMP_DN},
         '{32'd31603, 0, 16'd0,     1, 16'd0,     0, 0, 3'd0, 1, 0,
           MODE_BOOT, SND_NONE, BLD_NONE},
         // release after ramp down, at the top of the time range
         '{32'hFFFFFFFF, 0, 16'd0,  0, 16'd0,     0, 0, 3'd0, 0, 0,
           MODE_BOOT, SND_NONE, BLD_NONE}
      };

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed passes at reset settings
      for (k = 0; k < DRILL_ROWS; k++) begin
         r = '0;
         r.now_ms             = drill[k].now;
         r.act_pulse_edge     = drill[k].pedge;
         r.act_pulse_width_ms = drill[k].pwidth;
         r.act_held           = drill[k].held;
         r.act_held_ms        = drill[k].held_ms;
         r.clash_seen         = drill[k].clash;
         r.swing_seen         = drill[k].swing;
         r.swing_magnitude    = drill[k].mag;
         r.blade_done         = drill[k].done;
         t.mode      = drill[k].mode;
         t.sound_cmd = drill[k].snd;
         t.blade_cmd = drill[k].blade;
         send_pass(r, $urandom_range(0, send_max), drill[k].typed, t);
      end
      wall_ms = drill[DRILL_ROWS-1].now;
      drain();

      // random phases, each under its own register setting
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               cset.debounce_ms = 16'd50;      cset.power_down_hold_ms = 16'd1500;
               cset.min_swing_ms = 16'd200;    cset.max_swing_ms = 16'd1000;
               cset.clash_pulse_ms = 16'd100;  cset.post_clash_ms = 16'd1000;
               cset.hum_relaunch_ms = 20'd30000; cset.swing_threshold = 3'd1;
            end
            1: cset = '0;
            2: cset = '1;
            4: begin
               cset.debounce_ms        = 16'($urandom);
               cset.power_down_hold_ms = 16'($urandom);
               cset.min_swing_ms       = 16'($urandom);
               cset.max_swing_ms       = 16'($urandom);
               cset.clash_pulse_ms     = 16'($urandom);
               cset.post_clash_ms      = 16'($urandom);
               cset.hum_relaunch_ms    = 20'($urandom);
               cset.swing_threshold    = 3'($urandom);
            end
            default: begin
               cset.debounce_ms        = 16'($urandom_range(0, 300));
               cset.power_down_hold_ms = 16'($urandom_range(0, 3000));
               cset.min_swing_ms       = 16'($urandom_range(0, 400));
               cset.max_swing_ms       = 16'($urandom_range(0, 2000));
               cset.clash_pulse_ms     = 16'($urandom_range(0, 300));
               cset.post_clash_ms      = 16'($urandom_range(0, 2000));
               cset.hum_relaunch_ms    = 20'($urandom_range(0, 5000));
               cset.swing_threshold    = 3'($urandom_range(0, 7));
            end
         endcase
         write_settings(cset);
         settings_done++;
         send_max = phase_send[ph];
         recv_max = phase_recv[ph];
         for (n = 0; n < int'(phase_len[ph]); n++) begin
            r = make_pass();
            send_pass(r, $urandom_range(0, send_max), 1'b0, '0);
         end
         drain();
      end

      repeat (6) @(posedge clock);
      $display("%0d passes sent under %0d register settings, %0d results checked",
               passes_sent, settings_done + 1, rsp_seen);
      $display("modes visited (bit per mode code): %b, mismatches: %0d",
               modes_seen, failures);
      if (failures == 0 && due_cmds.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
hdl/sms_pkg.sv
hdl/sms_csr.sv
hdl/sms_step.sv
hdl/saber_mode_sequencer.sv
verif/saber_mode_sequencer_test.sv
